// ===== sv/sfra_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sfra_pkg;

    localparam int BYTE_W      = 8;
    localparam int IDX_W       = 4;
    localparam int CNT_W       = 8;
    localparam int SAMPLE_W    = 16;
    localparam int AVG_W       = 24;
    localparam int FRAC_W      = 8;
    localparam int ACC_W       = 32;
    localparam int STEP_W      = $clog2(ACC_W);
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_FIELD_W = AVG_W + SAMPLE_W + STATUS_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic [IDX_W-1:0] HIGH_POS  = IDX_W'(3);
    localparam logic [IDX_W-1:0] LOW_POS   = IDX_W'(4);
    localparam logic [IDX_W-1:0] INDEX_MAX = '1;

    localparam logic [CNT_W-1:0] MAX_COUNT_RST = CNT_W'(16);

    typedef enum logic [STATUS_W-1:0] {
        STAT_UPDATED = 2'd0,
        STAT_ZERO    = 2'd1,
        STAT_SHORT   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_START,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

// ===== sv/sensor_frame_running_average.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   | direction | tdata (low bit up)                                   | tuser / tlast
// ----------+-----------+------------------------------------------------------+--------------------
// s_axis    | in        | [7:0] rx_byte                                        | tlast = frame_end
// m_axis    | out       | [23:0] average_q8, [39:24] sample_tenths,            | none
//           |           | [41:40] status, [47:42] zero                         |
// cfg       | in        | cfg_wdata = max_count, written when cfg_we is high   | none
//
// bytes without frame end are taken back to back while the block is idle
// a frame end byte of a short frame or a zero reading passes through the eval and
// output states, and the result is then loaded into the output register
// an updating frame end passes through the eval, multiply, divider start, divide and
// output states: the product term is registered, then the restoring divider produces
// one quotient bit per cycle
// the input is stalled while a frame end is worked on, and the result waits in the
// output register until taken; rst_n clears control state, average and count, and
// sets the cap to 16
module sensor_frame_running_average (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [sfra_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] rx_byte
    input  wire logic                             s_axis_tlast,  // frame_end
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [sfra_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,  // average_q8, sample_tenths,
                                                                  // status, zero fill
    input  wire logic                             cfg_we,
    input  wire logic [sfra_pkg::CNT_W-1:0]       cfg_wdata      // max_count
);
    import sfra_pkg::*;

    // fsm
    state_t state_reg;
    state_t state_next;

    // control decoded from state
    logic in_accept;
    logic eval_en;
    logic acc_load;
    logic div_start;
    logic out_load;

    // frame capture
    logic [IDX_W-1:0]  byte_index_reg;
    logic [BYTE_W-1:0] high_byte_reg;
    logic [BYTE_W-1:0] low_byte_reg;
    logic              frame_ok_reg;

    // averaging state
    logic [CNT_W-1:0]  max_count_reg;
    logic [CNT_W-1:0]  sample_count_reg;
    logic [AVG_W-1:0]  average_reg;
    logic [ACC_W-1:0]  acc_reg;
    status_t           status_reg;

    // output register
    logic                m_valid_reg;
    logic [AVG_W-1:0]    out_avg_reg;
    logic [SAMPLE_W-1:0] out_sample_reg;
    status_t             out_status_reg;

    logic [SAMPLE_W-1:0] reading;
    logic [CNT_W-1:0]    cap;
    logic [CNT_W-1:0]    count_m1;
    logic [ACC_W-1:0]    product;
    logic [ACC_W-1:0]    acc_next;
    logic                div_done;
    logic [ACC_W-1:0]    div_quot;
    logic                out_free;

    assign reading  = {high_byte_reg, low_byte_reg};
    // a cap of zero acts as one
    assign cap      = (max_count_reg == '0) ? CNT_W'(1) : max_count_reg;
    assign count_m1 = sample_count_reg - CNT_W'(1);
    // avg * (n - 1) + v * 256, always below 2^32 since the quotient fits 24 bits
    assign product  = {{(ACC_W-AVG_W){1'b0}}, average_reg}
                      * {{(ACC_W-CNT_W){1'b0}}, count_m1};
    assign acc_next = product + {{(ACC_W-SAMPLE_W-FRAC_W){1'b0}}, reading, {FRAC_W{1'b0}}};
    assign out_free = ~m_valid_reg | m_axis_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tlast)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (frame_ok_reg && (reading != '0))
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_MUL:   state_next = ST_START;
            ST_START: state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs of the fsm
    always_comb
    begin
        s_axis_tready = 1'b0;
        eval_en       = 1'b0;
        acc_load      = 1'b0;
        div_start     = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_EVAL:  eval_en       = 1'b1;
            ST_MUL:   acc_load      = 1'b1;
            ST_START: div_start     = 1'b1;
            ST_DIV:   ;
            ST_OUT:   out_load      = out_free;
            default:  ;
        endcase
    end

    assign in_accept = s_axis_tvalid & s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // config register; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_count_reg <= MAX_COUNT_RST;
        end
        else if (cfg_we)
        begin
            max_count_reg <= cfg_wdata;
        end
    end

    // byte counter and capture of bytes 3 and 4
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= '0;
            high_byte_reg  <= '0;
            low_byte_reg   <= '0;
            frame_ok_reg   <= 1'b0;
        end
        else if (in_accept)
        begin
            if (byte_index_reg == HIGH_POS)
            begin
                high_byte_reg <= s_axis_tdata[BYTE_W-1:0];
            end
            else if (byte_index_reg == LOW_POS)
            begin
                low_byte_reg <= s_axis_tdata[BYTE_W-1:0];
            end
            if (s_axis_tlast)
            begin
                byte_index_reg <= '0;
                // at least five bytes including this one
                frame_ok_reg   <= (byte_index_reg >= LOW_POS);
            end
            else if (byte_index_reg != INDEX_MAX)
            begin
                byte_index_reg <= byte_index_reg + IDX_W'(1);
            end
        end
    end

    // count, average and status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= '0;
            average_reg      <= '0;
            status_reg       <= STAT_UPDATED;
        end
        else
        begin
            if (eval_en)
            begin
                if (!frame_ok_reg)
                begin
                    status_reg <= STAT_SHORT;
                end
                else if (reading == '0)
                begin
                    status_reg <= STAT_ZERO;
                end
                else
                begin
                    status_reg <= STAT_UPDATED;
                    // a count above a lowered cap is kept as it is
                    if (sample_count_reg < cap)
                    begin
                        sample_count_reg <= sample_count_reg + CNT_W'(1);
                    end
                end
            end
            if ((state_reg == ST_DIV) && div_done)
            begin
                average_reg <= div_quot[AVG_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_load)
        begin
            acc_reg <= acc_next;
        end
    end

    sfra_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (sample_count_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // output register, frees while the next frame is taken in
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_avg_reg    <= average_reg;
            out_sample_reg <= (status_reg == STAT_SHORT) ? '0 : reading;
            out_status_reg <= status_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_FIELD_W){1'b0}},
                            out_status_reg, out_sample_reg, out_avg_reg};

endmodule

`default_nettype wire

// ===== sv/sfra_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per cycle
module sfra_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [sfra_pkg::ACC_W-1:0] dividend,
    input  wire logic [sfra_pkg::CNT_W-1:0] divisor,
    output logic                            done,
    output logic [sfra_pkg::ACC_W-1:0]      quotient
);
    import sfra_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [ACC_W-1:0]  dvd_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  dsr_reg;

    logic [CNT_W:0]    rem_shift;
    logic [CNT_W+1:0]  diff;
    logic              q_bit;

    // shift in next dividend bit, trial subtract
    assign rem_shift = {rem_reg, dvd_reg[ACC_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, dsr_reg};
    assign q_bit     = ~diff[CNT_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(ACC_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            // dividend register fills up with quotient bits from the bottom
            dvd_reg <= {dvd_reg[ACC_W-2:0], q_bit};
            rem_reg <= q_bit ? diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

// checks sensor_frame_running_average against a cycle-free predictor of the frame
// average; bytes go in over the s_axis side, one result per frame end comes back on
// the m_axis side and is compared field by field with the oldest expected result
module tb;

    import sfra_pkg::*;

    localparam int unsigned READ_HI_AT     = 3;
    localparam int unsigned READ_LO_AT     = 4;
    localparam int unsigned FRAME_MIN_LEN  = 5;
    localparam int unsigned SETTLE_CYCLES  = 60;   // longer than the longest frame end
    localparam int unsigned HOLD_CYCLES    = 400;  // long receiver back-pressure
    localparam int unsigned WATCHDOG_LIMIT = 2000; // cycles with no transaction at all
    localparam int unsigned MAX_REPORTS    = 10;

    typedef struct {
        logic [7:0]  rx;
        logic        last;
        int unsigned gap;   // idle cycles before this byte is offered
    } byte_item_t;

    typedef struct packed {
        logic [23:0] avg_q8;
        logic [15:0] tenths;
        status_t     status;
    } frame_result_t;

    logic                    clk            = 1'b0;
    logic                    rst_n          = 1'b0;
    logic                    s_axis_tvalid  = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata   = '0;   // [7:0] rx_byte
    logic                    s_axis_tlast   = 1'b0; // frame_end
    logic                    m_axis_tvalid;
    logic                    m_axis_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;          // average_q8, sample_tenths, status
    logic                    cfg_we         = 1'b0;
    logic [CNT_W-1:0]        cfg_wdata      = '0;   // max_count

    sensor_frame_running_average dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state, mirrors the block after reset
    logic [3:0]  byte_pos_m = '0;
    logic [7:0]  hi_byte_m  = '0;
    logic [7:0]  lo_byte_m  = '0;
    logic [7:0]  count_m    = '0;
    logic [23:0] avg_q8_m   = '0;
    logic [7:0]  cap_m      = MAX_COUNT_RST;

    byte_item_t    pending_bytes[$];
    frame_result_t expected_frames[$];

    bit          in_fire;
    bit          out_fire;
    bit          src_burst;
    bit          snk_burst;
    bit          hold_req;
    int unsigned bytes_queued;
    int unsigned mismatches;
    int unsigned quiet_cycles;

    // one accepted byte; pushes the expected result when it closes a frame
    function automatic void predict_frame_byte(input logic [7:0] rx, input logic last);
        logic [4:0]        frame_len;
        logic [15:0]       reading;
        logic [7:0]        cap;
        longint unsigned   acc;
        frame_result_t     res;
        if (byte_pos_m == 4'(READ_HI_AT))
            hi_byte_m = rx;
        else if (byte_pos_m == 4'(READ_LO_AT))
            lo_byte_m = rx;
        frame_len = {1'b0, byte_pos_m} + 5'd1;
        if (byte_pos_m != 4'hF)
            byte_pos_m = byte_pos_m + 4'd1;
        if (last)
        begin
            byte_pos_m = '0;
            reading    = '0;
            if (frame_len < 5'(FRAME_MIN_LEN))
                res.status = STAT_SHORT;
            else
            begin
                reading = {hi_byte_m, lo_byte_m};
                if (reading == '0)
                    res.status = STAT_ZERO;
                else
                begin
                    // a cap of zero behaves as one; a lowered cap never shrinks the count
                    cap = (cap_m == '0) ? 8'd1 : cap_m;
                    if (count_m < cap)
                        count_m = count_m + 8'd1;
                    acc = 64'(avg_q8_m) * 64'(count_m - 8'd1) + (64'(reading) << 8);
                    avg_q8_m   = 24'(acc / 64'(count_m));
                    res.status = STAT_UPDATED;
                end
            end
            res.avg_q8 = avg_q8_m;
            res.tenths = reading;
            expected_frames.push_back(res);
        end
    endfunction

    // sample both handshakes at the rising edge, predict and check
    always @(posedge clk)
    begin : monitor
        frame_result_t want;
        logic [23:0]   got_avg;
        logic [15:0]   got_tenths;
        status_t       got_status;
        in_fire    = rst_n && s_axis_tvalid && s_axis_tready;
        out_fire   = rst_n && m_axis_tvalid && m_axis_tready;
        got_avg    = m_axis_tdata[23:0];
        got_tenths = m_axis_tdata[39:24];
        got_status = status_t'(m_axis_tdata[41:40]);
        if (in_fire)
            predict_frame_byte(s_axis_tdata[7:0], s_axis_tlast);
        if (out_fire)
        begin
            if (expected_frames.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: avg %h tenths %h status %s",
                             got_avg, got_tenths, got_status.name());
            end
            else
            begin
                want = expected_frames.pop_front();
                if (got_avg !== want.avg_q8 || got_tenths !== want.tenths
                    || got_status !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("mismatch: exp avg %h tenths %h status %s",
                                 want.avg_q8, want.tenths, want.status.name());
                        $display("          got avg %h tenths %h status %s",
                                 got_avg, got_tenths, got_status.name());
                    end
                end
            end
        end
    end

    // byte driver: offers the next queued byte after its idle gap
    always @(negedge clk)
    begin : driver
        bit          vld;
        byte_item_t  it;
        static bit          gap_loaded = 1'b0;
        static int unsigned gap_left   = 0;
        if (rst_n)
        begin
            vld = s_axis_tvalid && !in_fire;
            if (!vld && pending_bytes.size() != 0)
            begin
                if (!gap_loaded)
                begin
                    gap_left   = pending_bytes[0].gap;
                    gap_loaded = 1'b1;
                end
                if (gap_left > 0)
                    gap_left--;
                else
                begin
                    it           = pending_bytes.pop_front();
                    gap_loaded   = 1'b0;
                    vld          = 1'b1;
                    s_axis_tdata <= it.rx;
                    s_axis_tlast <= it.last;
                end
            end
            s_axis_tvalid <= vld;
        end
    end

    // result sink: random wait after each transaction, plus one long hold-off
    always @(negedge clk)
    begin : sink
        bit                 rdy;
        static int unsigned snk_wait  = 0;
        static int unsigned hold_left = 0;
        if (rst_n)
        begin
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else
            begin
                if (out_fire)
                begin
                    if ($urandom_range(0, 9) == 0)
                        snk_burst = !snk_burst;
                    snk_wait = snk_burst ? 0 : $urandom_range(0, 15);
                end
                if (snk_wait > 0)
                begin
                    snk_wait--;
                    rdy = 1'b0;
                end
                else
                    rdy = 1'b1;
            end
            m_axis_tready <= rdy;
        end
    end

    // ends a hung run: too long without any transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // queue one frame; optionally force the reading bytes
    task automatic queue_frame(input int unsigned len, input bit set_reading,
                               input logic [15:0] reading);
        byte_item_t  it;
        int unsigned i;
        for (i = 0; i < len; i++)
        begin
            it.rx = 8'($urandom_range(0, 255));
            if (set_reading && i == READ_HI_AT)
                it.rx = reading[15:8];
            if (set_reading && i == READ_LO_AT)
                it.rx = reading[7:0];
            it.last = (i == len - 1);
            it.gap  = src_burst ? 0 : $urandom_range(0, 15);
            pending_bytes.push_back(it);
        end
        bytes_queued += len;
        if ($urandom_range(0, 9) == 0)
            src_burst = !src_burst;
    endtask

    // mostly well-formed frames with random content, some short, long and zero ones
    task automatic queue_random_frames(input int unsigned n_bytes);
        int unsigned target;
        int unsigned pick;
        target = bytes_queued + n_bytes;
        while (bytes_queued < target)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 2)
                queue_frame($urandom_range(1, 4), 1'b0, '0);
            else if (pick < 4)
                queue_frame($urandom_range(6, 24), 1'b0, '0);   // counter saturates past 16
            else if (pick < 6)
                queue_frame($urandom_range(5, 7), 1'b1, 16'h0000);
            else if (pick == 6)
                queue_frame(FRAME_MIN_LEN, 1'b1,
                            ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0001);
            else
                queue_frame($urandom_range(5, 8), 1'b0, '0);
        end
    endtask

    // sender pauses until every result is back and the block has gone quiet
    task automatic wait_idle();
        while (pending_bytes.size() != 0 || s_axis_tvalid || expected_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cap(input logic [7:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cap_m      = value;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: short frames, zero reading, reading extremes, default cap
        queue_frame(1, 1'b0, '0);
        queue_frame(4, 1'b0, '0);
        queue_frame(FRAME_MIN_LEN, 1'b1, 16'h0000);
        queue_frame(FRAME_MIN_LEN, 1'b1, 16'hFFFF);
        queue_frame(FRAME_MIN_LEN, 1'b1, 16'h0001);
        wait_idle();

        // cap of one, below the count left by the directed frames, which is kept
        write_cap(8'd1);
        queue_random_frames(70);
        wait_idle();

        // widest cap, with the receiver holding off so the input stalls
        write_cap(8'd255);
        hold_req = 1'b1;
        queue_random_frames(150);
        wait_idle();

        // cap lowered under the running count
        write_cap(8'd2);
        queue_random_frames(60);
        wait_idle();

        // cap of zero
        write_cap(8'd0);
        queue_random_frames(50);
        wait_idle();

        write_cap(8'($urandom_range(3, 254)));
        queue_random_frames(70);
        wait_idle();

        if (mismatches == 0 && expected_frames.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
